// ===== design/psq_pkg.sv =====
package psq_pkg;

   // Fixed field widths of the request and response beats.
   localparam int CMD_W    = 1;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Request beat layout: tdata holds position then value, padded to whole bytes.
   localparam int REQ_DATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;
   // Response beat layout: removed value, status, count, empty flag.
   localparam int RSP_DATA_W = ((VALUE_W + STATUS_W + COUNT_W + 1 + 7) / 8) * 8;

   // Command codes carried in req_tuser.
   localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Operation broadcast to every cell of the shift row.
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } cell_op_type;

endpackage

// ===== design/psq_cell.sv =====
module psq_cell
   import psq_pkg::*;
#(
   parameter int DATA_W = 32,
   parameter int CMP_W  = 5,
   parameter int INDEX  = 0
) (
   input  logic              clock,
   input  cell_op_type       op,
   input  logic [CMP_W-1:0]  pos,
   input  logic [DATA_W-1:0] value,
   input  logic [DATA_W-1:0] left_data,
   input  logic [DATA_W-1:0] right_data,
   output logic [DATA_W-1:0] data,
   output logic [DATA_W-1:0] sel_data
);

   localparam logic [CMP_W-1:0] MY_INDEX = CMP_W'(INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // Each cell compares its own index with the position and picks its source.
   always_comb begin
      data_in = data_ff;
      unique case (op)
         OP_INSERT: begin
            priority if (MY_INDEX > pos) begin
               data_in = left_data;
            end else if (MY_INDEX == pos) begin
               data_in = value;
            end else begin
               data_in = data_ff;
            end
         end
         OP_REMOVE: begin
            if (MY_INDEX >= pos) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // Entry storage carries no reset; entries beyond the count are never shown.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign sel_data = (MY_INDEX == pos) ? data_ff : '0;

endmodule

// ===== design/positional_shift_queue.sv =====
// Ordered list of up to CAPACITY entries held in a row of shift cells. An insert
// beat (req_tuser 0) places a value at a position from 0 to count and moves the
// later entries up; a remove beat (req_tuser 1) takes out the entry at a position
// below count, moves the later entries down and returns it. A bad position gives
// status 1, an insert into a full list status 2, and the list is left unchanged.
// Every request beat yields exactly one response beat carrying the count and an
// empty flag. One command is taken per clock: all cells compare their index with
// the position and shift in the same cycle, and the response appears in the
// output register in the cycle after the request beat is accepted. The only limit
// on throughput is the output register, which accepts a new request while its
// beat is being taken. No clearing pass is needed after reset.
module positional_shift_queue
   import psq_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int DATA_W   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [4:0] position, [36:5] value, [39:37] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] cmd
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] removed_value, [33:32] status, [38:34] count, [39] is_empty
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_tvalid_ff;
   logic                  rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_in;

   logic                  accept;
   logic                  is_insert;
   logic [POS_W-1:0]      req_position;
   logic [VALUE_W-1:0]    req_value;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      count_ext;
   logic [DATA_W-1:0]     value_in;
   status_type            status;
   cell_op_type           op;
   logic [VALUE_W-1:0]    removed_value;

   logic [DATA_W-1:0]     cell_data [CAPACITY];
   logic [DATA_W-1:0]     cell_sel  [CAPACITY];
   logic [DATA_W-1:0]     sel_or;

   // Unpack the request beat.
   assign req_position = req_tdata[POS_W-1:0];
   assign req_value    = req_tdata[POS_W+VALUE_W-1:POS_W];
   assign is_insert    = (req_tuser == CMD_INSERT);
   assign pos_ext      = CMP_W'(req_position);
   assign count_ext    = CMP_W'(count_ff);
   assign value_in     = DATA_W'(req_value);

   // The output register is free or being emptied in this cycle.
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Range check comes before the full check.
   always_comb begin
      status = ST_DONE;
      if (is_insert) begin
         priority if (pos_ext > count_ext) begin
            status = ST_RANGE;
         end else if (count_ff == CAP_COUNT) begin
            status = ST_FULL;
         end else begin
            status = ST_DONE;
         end
      end else begin
         if (pos_ext >= count_ext) begin
            status = ST_RANGE;
         end
      end
   end

   // Operation broadcast to the cell row and the next count.
   always_comb begin
      op       = OP_HOLD;
      count_in = count_ff;
      if (accept && (status == ST_DONE)) begin
         if (is_insert) begin
            op       = OP_INSERT;
            count_in = count_ff + CNT_W'(1);
         end else begin
            op       = OP_REMOVE;
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   // Row of cells, each handing data to its neighbors.
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;

      if (gi == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_left
         assign left_data = cell_data[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_right
         assign right_data = cell_data[gi+1];
      end

      psq_cell #(
         .DATA_W (DATA_W),
         .CMP_W  (CMP_W),
         .INDEX  (gi)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .pos        (pos_ext),
         .value      (value_in),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[gi]),
         .sel_data   (cell_sel[gi])
      );
   end

   // Only the cell at the position drives a nonzero word, so an OR picks it.
   always_comb begin
      sel_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_or = sel_or | cell_sel[i];
      end
   end

   assign removed_value = (!is_insert && (status == ST_DONE)) ? VALUE_W'(sel_or) : '0;

   // Response beat assembly and output register control.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (accept) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = RSP_DATA_W'({(count_in == '0), COUNT_W'(count_in),
                                      status, removed_value});
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef NO_ASSERTIONS
   // The count never goes beyond the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("count exceeds capacity");

   // A refused command leaves the count unchanged.
   a_error_hold: assert property (@(posedge clock) disable iff (reset)
      accept && (status != ST_DONE) |=> count_ff == $past(count_ff))
      else $error("count changed on a refused command");

   // A successful insert grows the list by exactly one entry.
   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      accept && is_insert && (status == ST_DONE)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the list by one");

   // Full status is only reported when the list really is full.
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      accept && (status == ST_FULL) |-> count_ff == CAP_COUNT)
      else $error("full status on a list that is not full");
`endif

endmodule

// ===== bench/tb_positional_shift_queue.sv =====
module tb_positional_shift_queue;
   timeunit 1ns;
   timeprecision 1ps;

   import psq_pkg::*;

   localparam int LIST_DEPTH   = 16;
   localparam int ITEM_DATA_W  = 32;
   localparam int PHASE_ITEMS  = 275;
   localparam int DRAIN_LIMIT  = 10000;

   // Response beat as it appears on rsp_tdata, highest field first.
   typedef struct packed {
      logic                is_empty;
      logic [COUNT_W-1:0]  count;
      status_type          status;
      logic [VALUE_W-1:0]  removed_value;
   } list_result_type;

   // Shadow copy of the list that predicts every response beat.
   class list_scoreboard;
      logic [VALUE_W-1:0] shadow_entries[LIST_DEPTH];
      int unsigned        fill_count;
      list_result_type    expected_q[$];
      int unsigned        mismatches;

      function new();
         fill_count = 0;
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void flag(string what, logic [VALUE_W-1:0] exp_val, logic [VALUE_W-1:0] act_val);
         mismatches++;
         if (mismatches <= 10)
            $display("Mismatch in %s: expected %0h, got %0h", what, exp_val, act_val);
      endfunction

      // Applies one accepted request beat to the shadow list.
      function void note_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                 logic [VALUE_W-1:0] value);
         list_result_type res;
         res.removed_value = '0;
         res.status        = ST_DONE;
         if (cmd == CMD_INSERT) begin
            if (pos > fill_count) begin
               res.status = ST_RANGE;
            end else if (fill_count >= LIST_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (int i = fill_count; i > pos; i--)
                  shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[pos] = value;
               fill_count++;
            end
         end else begin
            if (pos >= fill_count) begin
               res.status = ST_RANGE;
            end else begin
               res.removed_value = shadow_entries[pos];
               for (int i = pos + 1; i < fill_count; i++)
                  shadow_entries[i-1] = shadow_entries[i];
               fill_count--;
            end
         end
         res.count    = fill_count[COUNT_W-1:0];
         res.is_empty = (fill_count == 0);
         expected_q.push_back(res);
      endfunction

      // Compares one accepted response beat with the oldest prediction.
      function void check_response(logic [RSP_DATA_W-1:0] beat);
         list_result_type got;
         list_result_type want;
         got = list_result_type'(beat);
         if (expected_q.size() == 0) begin
            flag("unexpected response beat", '0, beat[VALUE_W-1:0]);
            return;
         end
         want = expected_q.pop_front();
         if (got.removed_value !== want.removed_value)
            flag("removed_value", want.removed_value, got.removed_value);
         if (got.status !== want.status)
            flag("status", want.status, got.status);
         if (got.count !== want.count)
            flag("count", want.count, got.count);
         if (got.is_empty !== want.is_empty)
            flag("is_empty", want.is_empty, got.is_empty);
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = CMD_INSERT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int unsigned idle_pct  = 0;
   int unsigned stall_pct = 0;

   list_scoreboard list_sb = new();

   positional_shift_queue #(
      .CAPACITY(LIST_DEPTH),
      .DATA_W  (ITEM_DATA_W)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Response side: check each accepted beat, then pick the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         list_sb.check_response(rsp_tdata);
      rsp_tready <= reset ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
   end

   // Hard stop in case the handshake hangs.
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Drives one request beat after a random gap and waits until it is taken.
   task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic [VALUE_W-1:0] value);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_DATA_W - POS_W - VALUE_W){1'b0}}, value, pos};
      do @(posedge clock); while (!req_tready);
      list_sb.note_request(cmd, pos, value);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Random traffic in bursts that lean toward filling or draining the list.
   task automatic run_phase(input int unsigned n_items, input int unsigned gap_pct,
                            input int unsigned hold_pct);
      int unsigned insert_pct;
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] pos;
      idle_pct   = gap_pct;
      stall_pct  = hold_pct;
      insert_pct = 50;
      for (int n = 0; n < n_items; n++) begin
         if (n % 32 == 0) begin
            case ($urandom_range(0, 2))
               0: insert_pct = 85;
               1: insert_pct = 15;
               default: insert_pct = 50;
            endcase
         end
         cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
         // Mostly legal positions; the rest cover the whole field.
         if ($urandom_range(0, 9) == 0)
            pos = POS_W'($urandom_range(0, 31));
         else if (cmd == CMD_INSERT)
            pos = POS_W'($urandom_range(0, list_sb.fill_count));
         else
            pos = (list_sb.fill_count == 0) ? '0 :
                  POS_W'($urandom_range(0, list_sb.fill_count - 1));
         send_req(cmd, pos, pick_value());
      end
   endtask

   initial begin
      int unsigned guard;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-list errors, edge values, fill to capacity, full and range errors.
      send_req(CMD_REMOVE, 0, '0);
      send_req(CMD_INSERT, 1, 32'h1234_5678);
      send_req(CMD_INSERT, 0, '0);
      send_req(CMD_INSERT, 1, '1);
      while (list_sb.fill_count < LIST_DEPTH)
         send_req(CMD_INSERT, POS_W'($urandom_range(0, list_sb.fill_count)), $urandom);
      send_req(CMD_INSERT, 16, 32'hA5A5_5A5A);
      send_req(CMD_INSERT, 17, 32'h5A5A_A5A5);
      send_req(CMD_REMOVE, 16, '1);
      send_req(CMD_REMOVE, 15, '0);
      send_req(CMD_REMOVE, 0, '0);
      send_req(CMD_REMOVE, 7, '0);
      send_req(CMD_INSERT, 31, '1);

      run_phase(PHASE_ITEMS, 0, 0);
      run_phase(PHASE_ITEMS, 47, 0);
      run_phase(PHASE_ITEMS, 0, 47);
      run_phase(PHASE_ITEMS, 36, 36);

      // Let the last responses come back.
      req_tvalid <= 1'b0;
      guard = 0;
      while (list_sb.pending() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
      if (list_sb.pending() != 0)
         list_sb.flag("responses never seen", list_sb.pending(), '0);

      if (list_sb.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
